// ===== sv/gf13_pkg.sv =====
package gf13_pkg;
    localparam int FIELD_DEGREE = 13;
    localparam logic [FIELD_DEGREE-1:0] RED_POLY = 13'h001B;
    // cells in the chain: the inverse needs 16 multiply/square steps
    localparam int N_CELLS = 16;

    typedef logic [FIELD_DEGREE-1:0] t_elem;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_MUL  = 3'd1,
        OP_SQR  = 3'd2,
        OP_SQRT = 3'd3,
        OP_INV  = 3'd4
    } t_op;

    typedef struct packed {
        logic  vld;
        t_op   op;
        t_elem a;
        t_elem b;
        t_elem x;
        t_elem y;
    } t_beat;

    function automatic t_elem gf_mul(input t_elem a, input t_elem b);
        logic [FIELD_DEGREE:0] acc;
        acc = '0;
        for (int i = FIELD_DEGREE - 1; i >= 0; i--) begin
            acc = {acc[FIELD_DEGREE-1:0], 1'b0};
            if (acc[FIELD_DEGREE]) acc = {1'b0, acc[FIELD_DEGREE-1:0] ^ RED_POLY};
            if (b[i]) acc = acc ^ {1'b0, a};
        end
        return acc[FIELD_DEGREE-1:0];
    endfunction
endpackage

// ===== sv/gf13_cell.sv =====
module gf13_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_stall,
    input  logic [3:0]           i_idx,
    input  gf13_pkg::t_beat      i_beat,
    output gf13_pkg::t_beat      o_beat
);
    import gf13_pkg::*;

    t_beat n_beat;
    t_beat r_beat;
    t_elem w_sq;
    t_elem w_mo;
    t_elem w_m;

    // one multiplier per cell; squaring feeds x twice
    always_comb begin
        w_mo = i_beat.x;
        if (i_beat.op == OP_INV) begin
            if (i_idx == 4'd2 || i_idx == 4'd7 || i_idx == 4'd14) w_mo = i_beat.y;
            else if (i_idx == 4'd3) w_mo = i_beat.a;
        end
        w_m  = gf_mul(i_beat.x, w_mo);
        w_sq = w_m;
        n_beat = i_beat;
        unique case (i_beat.op)
            OP_SQRT: if (i_idx < 4'd12) n_beat.x = w_sq;
            OP_INV: begin
                n_beat.x = w_m;
                // keep p2 for the p4*p2 product, later p7 and p63
                if (i_idx == 4'd0 || i_idx == 4'd3 || i_idx == 4'd7) n_beat.y = w_m;
            end
            default: ;
        endcase
    end

    // stage map (inverse): 0 p2, 1 p4, 2 p6, 3 p7, 4..6 p7^8, 7 p63,
    // 8..13 p63^64, 14 p4095, 15 p8190
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else if (!i_stall) begin
            r_beat.vld <= i_beat.vld;
        end
        if (!i_stall) begin
            r_beat.op <= i_beat.op;
            r_beat.a  <= i_beat.a;
            r_beat.b  <= i_beat.b;
            r_beat.x  <= n_beat.x;
            r_beat.y  <= n_beat.y;
        end
    end

    assign o_beat = r_beat;
endmodule

// ===== sv/gf2_13_arithmetic_unit.sv =====
// GF(2^13) arithmetic unit, polynomial z^13+z^4+z^3+z+1.
// Input channel: i_valid / o_stall with i_func, i_operand_a, i_operand_b.
// Output channel: o_valid / i_stall with o_result.
// A beat moves on a channel at a clock edge with valid high and stall low.
// Ops: add, multiply, square, square root (a^4096), inverse (a^8190, 0->0);
// other codes return zero.
// The datapath is a chain of 16 identical cells, each with one 13x13
// carry-less multiplier and a register; every op walks the whole chain,
// so each result passes the 16 cells and then a result stage.
// Throughput: one beat per unstalled cycle, set by one multiplier per cell.
// The whole chain advances together; it freezes only while a result waits
// in the output register under i_stall, and o_stall is high exactly then,
// so no beat is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
module gf2_13_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [12:0] i_operand_a,
    input  logic [12:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [12:0] o_result
);
    import gf13_pkg::*;

    t_beat w_chain [N_CELLS+1];
    logic  r_vld;
    t_elem r_res;
    t_elem n_res;
    logic  w_adv;

    // a stalled output holds; an empty output slot lets the chain move
    assign w_adv   = !(r_vld && i_stall);
    assign o_stall = !w_adv;

    assign w_chain[0] = '{vld: i_valid, op: t_op'(i_func), a: i_operand_a,
                          b: i_operand_b, x: i_operand_a, y: i_operand_a};

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        gf13_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_stall(!w_adv),
            .i_idx  (4'(g)),
            .i_beat (w_chain[g]),
            .o_beat (w_chain[g+1])
        );
    end

    // final op select; add, multiply and square happen here on carried operands
    always_comb begin
        case (w_chain[N_CELLS].op)
            OP_ADD:  n_res = w_chain[N_CELLS].a ^ w_chain[N_CELLS].b;
            OP_MUL:  n_res = gf_mul(w_chain[N_CELLS].a, w_chain[N_CELLS].b);
            OP_SQR:  n_res = gf_mul(w_chain[N_CELLS].a, w_chain[N_CELLS].a);
            OP_SQRT: n_res = w_chain[N_CELLS].x;
            OP_INV:  n_res = w_chain[N_CELLS].x;
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld <= w_chain[N_CELLS].vld;
        end
        if (w_adv) r_res <= n_res;
    end

    assign o_valid  = r_vld;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("result changed under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall without full output");
`endif
endmodule
